// ===== rtl/core/hnm_pkg.sv =====
// ----------------------------------------------------------------------------
// hnm_pkg
// Shared constants, register codes and the job record passed from the front
// end to the normal arithmetic of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hnm_pkg;

  // Line store depth and the widths that follow from it.
  localparam int LINE_MAX = 1024;
  localparam int COL_W    = $clog2(LINE_MAX);

  // Fixed field widths.
  localparam int HGT_W  = 8;
  localparam int PIX_W  = 7;
  localparam int HS_W   = 16;
  localparam int LEN_W  = 11;
  localparam int ROW_W  = 16;
  localparam int NRM_W  = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register reset values.
  localparam logic [PIX_W-1:0] GRID_PITCH_RST   = 7'd1;
  localparam logic [HS_W-1:0]  HEIGHT_SCALE_RST = 16'd803;
  localparam logic [LEN_W-1:0] ROW_LENGTH_RST   = 11'd1024;

  // Register indexes (word address).
  localparam logic [1:0] REG_GRID_PITCH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_ROW_LENGTH   = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One vertex to be worked on: the seven neighbourhood heights and the
  // edge flags that decide which neighbours collapse onto the centre.
  typedef struct packed {
    logic [HGT_W-1:0] mid0;
    logic [HGT_W-1:0] mid1;
    logic [HGT_W-1:0] mid2;
    logic [HGT_W-1:0] up1;
    logic [HGT_W-1:0] up2;
    logic [HGT_W-1:0] dn0;
    logic [HGT_W-1:0] dn1;
    logic             left_edge;
    logic             end_of_row;
    logic             top_row;
    logic             drain;
  } job_t;

endpackage

// ===== rtl/core/hnm_if.sv =====
// ----------------------------------------------------------------------------
// hnm_if
// Valid/ready channels for height samples in and unit normals out.
// ----------------------------------------------------------------------------
interface hnm_in_if;
  logic                      valid;
  logic                      ready;
  logic [hnm_pkg::HGT_W-1:0] height;
  logic                      drain;

  modport source (output valid, height, drain, input ready);
  modport sink   (input valid, height, drain, output ready);
endinterface

interface hnm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hnm_pkg::NRM_W-1:0] normal_x;
  logic signed [hnm_pkg::NRM_W-1:0] normal_y;
  logic signed [hnm_pkg::NRM_W-1:0] normal_z;
  logic                             end_of_row;
  logic                             end_of_frame;

  modport source (output valid, normal_x, normal_y, normal_z, end_of_row, end_of_frame,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, end_of_row, end_of_frame,
                  output ready);
endinterface

// ===== rtl/core/heightmap_normal_generator_unit.sv =====
// ----------------------------------------------------------------------------
// heightmap_normal_generator_unit
// Per-vertex unit normals of a raster heightmap, six triangles per vertex,
// emitted as signed Q1.14 one row behind the incoming samples.
//
//   channel  direction  payload
//   in_ch    in         height, drain
//   out_ch   out        normal_x, normal_y, normal_z, end_of_row, end_of_frame
//   APB      in/out     grid_pitch (0x0), height_scale (0x4), row_length (0x8)
//
// The front end takes an item while the job queue has room, then reads the line
// stores before it takes the next. Each normal occupies the back end through the
// bit-serial divide and square root shared by the three components and through
// the narrowing shifts; a zero sum skips the divide and square root.
// Reset is synchronous and active low; the line stores are not cleared.
// A stalled output holds its item while the back end works on the next one.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  hnm_in_if.sink                      in_ch,
  hnm_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hnm_pkg::ADDR_W-1:0]  paddr,
  input  logic [hnm_pkg::DATA_W-1:0]  pwdata,
  output logic [hnm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [hnm_pkg::PIX_W-1:0] grid_pitch_r;
  logic [hnm_pkg::HS_W-1:0]  height_scale_r;
  logic [hnm_pkg::LEN_W-1:0] row_length_r;
  logic                      wr_en;

  logic          q_push, q_full, q_pop, q_empty;
  hnm_pkg::job_t push_job, pop_job;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_pitch_r   <= hnm_pkg::GRID_PITCH_RST;
      height_scale_r <= hnm_pkg::HEIGHT_SCALE_RST;
      row_length_r   <= hnm_pkg::ROW_LENGTH_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        hnm_pkg::REG_GRID_PITCH:   grid_pitch_r   <= pwdata[hnm_pkg::PIX_W-1:0];
        hnm_pkg::REG_HEIGHT_SCALE: height_scale_r <= pwdata[hnm_pkg::HS_W-1:0];
        hnm_pkg::REG_ROW_LENGTH:   row_length_r   <= pwdata[hnm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hnm_pkg::REG_GRID_PITCH:   prdata = hnm_pkg::DATA_W'(grid_pitch_r);
      hnm_pkg::REG_HEIGHT_SCALE: prdata = hnm_pkg::DATA_W'(height_scale_r);
      hnm_pkg::REG_ROW_LENGTH:   prdata = hnm_pkg::DATA_W'(row_length_r);
      default:                   prdata = '0;
    endcase
  end

  hnm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .row_length (row_length_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  hnm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  hnm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_pitch   (grid_pitch_r),
    .height_scale (height_scale_r),
    .q_empty      (q_empty),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

endmodule

// ===== rtl/core/hnm_queue.sv =====
// ----------------------------------------------------------------------------
// hnm_queue
// Short job queue between the front end and the normal arithmetic.
// ----------------------------------------------------------------------------
module hnm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hnm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hnm_pkg::job_t pop_job,
  output logic          empty
);

  hnm_pkg::job_t                 entry_r [hnm_pkg::QUEUE_DEPTH];
  logic [hnm_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hnm_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [hnm_pkg::QPTR_W:0]      count_r, count_nxt;

  assign full    = (count_r == (hnm_pkg::QPTR_W+1)'(hnm_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hnm_pkg::QPTR_W'(hnm_pkg::QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == hnm_pkg::QPTR_W'(hnm_pkg::QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
    else $error("job pushed into a full queue");

endmodule

// ===== rtl/core/hnm_front.sv =====
// ----------------------------------------------------------------------------
// hnm_front
// Takes height items, keeps the two line stores and the row/column position,
// and gathers each vertex's neighbourhood into a job for the back end.
// ----------------------------------------------------------------------------
module hnm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  hnm_in_if.sink                     in_ch,
  input  logic [hnm_pkg::LEN_W-1:0]  row_length,
  input  logic                       q_full,
  output logic                       q_push,
  output hnm_pkg::job_t              q_job
);

  localparam int CMP_W = ((hnm_pkg::LEN_W > hnm_pkg::COL_W + 1) ?
                          hnm_pkg::LEN_W : hnm_pkg::COL_W + 1) + 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_RD   = 1'b1;

  logic state_r, state_nxt;

  logic [hnm_pkg::HGT_W-1:0] older_mem [hnm_pkg::LINE_MAX];
  logic [hnm_pkg::HGT_W-1:0] newer_mem [hnm_pkg::LINE_MAX];

  logic [hnm_pkg::HGT_W-1:0] older_a_r, older_b_r, newer_a_r, newer_b_r;

  logic [hnm_pkg::COL_W-1:0] col_r, col_nxt;
  logic [hnm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [hnm_pkg::HGT_W-1:0] prev_r, prev_nxt;
  logic [hnm_pkg::HGT_W-1:0] mleft_r, mleft_nxt;

  // Item captured at acceptance.
  logic [hnm_pkg::HGT_W-1:0] h_r;
  logic                      drain_r, eor_r;
  logic [hnm_pkg::COL_W-1:0] c_r;

  logic [CMP_W-1:0]          len_ext, len_clamp;
  logic [hnm_pkg::COL_W-1:0] last_col, c_sel, cr_sel;
  logic                      accept;

  logic                      wr_en;
  logic [hnm_pkg::HGT_W-1:0] wr_older, wr_newer;
  logic [hnm_pkg::HGT_W-1:0] mid0, dn1, dn0;

  always_comb begin
    len_ext = CMP_W'(row_length);
    if (len_ext < CMP_W'(2)) begin
      len_clamp = CMP_W'(2);
    end else if (len_ext > CMP_W'(hnm_pkg::LINE_MAX)) begin
      len_clamp = CMP_W'(hnm_pkg::LINE_MAX);
    end else begin
      len_clamp = len_ext;
    end
    last_col = hnm_pkg::COL_W'(len_clamp - CMP_W'(1));
    c_sel    = (col_r < last_col) ? col_r : last_col;
    cr_sel   = (c_sel < last_col) ? c_sel + 1'b1 : last_col;
  end

  assign in_ch.ready = (state_r == F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    mid0 = (c_r == '0) ? newer_a_r : mleft_r;
    dn1  = drain_r ? newer_a_r : h_r;
    dn0  = (c_r == '0) ? dn1 : prev_r;

    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    prev_nxt  = prev_r;
    mleft_nxt = mleft_r;
    wr_en     = 1'b0;
    wr_older  = h_r;
    wr_newer  = h_r;
    q_push    = 1'b0;

    q_job.mid0       = mid0;
    q_job.mid1       = newer_a_r;
    q_job.mid2       = newer_b_r;
    q_job.up1        = older_a_r;
    q_job.up2        = older_b_r;
    q_job.dn0        = dn0;
    q_job.dn1        = dn1;
    q_job.left_edge  = (c_r == '0);
    q_job.end_of_row = eor_r;
    q_job.top_row    = (row_r == hnm_pkg::ROW_W'(1));
    q_job.drain      = drain_r;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_RD;
        end
      end
      F_RD: begin
        state_nxt = F_IDLE;
        if (row_r == '0) begin
          // First row of a frame: only fill the stores.  A drain item here is dropped.
          if (!drain_r) begin
            wr_en    = 1'b1;
            prev_nxt = h_r;
            col_nxt  = eor_r ? '0 : c_r + 1'b1;
            if (eor_r) begin
              row_nxt = hnm_pkg::ROW_W'(1);
            end
          end
        end else begin
          q_push    = 1'b1;
          wr_en     = 1'b1;
          wr_older  = newer_a_r;
          wr_newer  = dn1;
          mleft_nxt = newer_a_r;
          prev_nxt  = dn1;
          col_nxt   = eor_r ? '0 : c_r + 1'b1;
          if (eor_r) begin
            if (drain_r) begin
              row_nxt = '0;
            end else if (row_r != '1) begin
              row_nxt = row_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      prev_r  <= '0;
      mleft_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      prev_r  <= prev_nxt;
      mleft_r <= mleft_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r     <= in_ch.height;
      drain_r <= in_ch.drain;
      c_r     <= c_sel;
      eor_r   <= (c_sel == last_col);
    end
  end

  // Line stores: two registered read ports and one write port each.
  always_ff @(posedge clk) begin
    if (accept) begin
      older_a_r <= older_mem[c_sel];
      older_b_r <= older_mem[cr_sel];
      newer_a_r <= newer_mem[c_sel];
      newer_b_r <= newer_mem[cr_sel];
    end
    if (wr_en) begin
      older_mem[c_r] <= wr_older;
      newer_mem[c_r] <= wr_newer;
    end
  end

  a_rd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_RD) |=> (state_r == F_IDLE))
    else $error("front end held in the store read cycle");

endmodule

// ===== rtl/core/hnm_back.sv =====
// ----------------------------------------------------------------------------
// hnm_back
// Sums the six triangle cross products of a job, scales them, and turns the
// sum into a rounded Q1.14 unit normal with a shared divider and square root.
// ----------------------------------------------------------------------------
module hnm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [hnm_pkg::PIX_W-1:0]  grid_pitch,
  input  logic [hnm_pkg::HS_W-1:0]   height_scale,
  input  logic                       q_empty,
  input  hnm_pkg::job_t              q_job,
  output logic                       q_pop,
  hnm_out_if.source                  out_ch
);

  localparam int ACC_W  = 15;
  localparam int ZACC_W = 8;
  localparam int PH_W   = hnm_pkg::PIX_W + hnm_pkg::HS_W;
  localparam int PP_W   = 2 * hnm_pkg::PIX_W;
  localparam int PX_W   = ACC_W - 1 + PH_W;
  localparam int PZ_W   = ZACC_W - 1 + PP_W;
  localparam int MAG_W  = PX_W + 12;
  localparam int SQ_W   = 32;
  localparam int M2_W   = SQ_W + 2;
  localparam int QD_W   = 31;
  localparam int Q_W    = 15;
  localparam logic [Q_W-1:0] ONE_Q = 15'd16384;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_TRI   = 4'd1;
  localparam logic [3:0] B_MUL1  = 4'd2;
  localparam logic [3:0] B_MUL2  = 4'd3;
  localparam logic [3:0] B_SHIFT = 4'd4;
  localparam logic [3:0] B_SQ    = 4'd5;
  localparam logic [3:0] B_SUM   = 4'd6;
  localparam logic [3:0] B_DIV   = 4'd7;
  localparam logic [3:0] B_SQRT  = 4'd8;
  localparam logic [3:0] B_DONE  = 4'd9;

  typedef struct packed {
    logic signed [1:0]         x;
    logic signed [1:0]         y;
    logic [hnm_pkg::HGT_W-1:0] h;
  } pt_t;

  typedef struct packed {
    logic signed [2:0] x;
    logic signed [2:0] y;
    logic signed [9:0] z;
  } vd_t;

  function automatic vd_t vsub(pt_t a, pt_t b);
    vd_t r;
    r.x = 3'(a.x) - 3'(b.x);
    r.y = 3'(a.y) - 3'(b.y);
    r.z = $signed({2'b00, a.h}) - $signed({2'b00, b.h});
    return r;
  endfunction

  logic [3:0]                state_r, state_nxt;
  hnm_pkg::job_t             job_r;
  logic [2:0]                tri_r;
  logic signed [ACC_W-1:0]   sx_r, sy_r;
  logic signed [ZACC_W-1:0]  sz_r;
  logic [PH_W-1:0]           ph_r;
  logic [PP_W-1:0]           pp_r;
  logic [MAG_W-1:0]          mx_r, my_r, mz_r;
  logic                      negx_r, negy_r, negz_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  logic [M2_W-1:0]           m2_r;
  logic [1:0]                comp_r;
  logic [4:0]                cnt_r;
  logic [M2_W-1:0]           rem_r;
  logic [QD_W-1:0]           quo_r;
  logic [3:0]                bit_r;
  logic [15:0]               res_r;
  logic [Q_W-1:0]            qx_r, qy_r, qz_r;

  logic                      out_valid_r;
  logic signed [hnm_pkg::NRM_W-1:0] nx_r, ny_r, nz_r;
  logic                      eor_out_r, eof_out_r;

  // Triangle operands.
  pt_t pc, pl, pr, pu, pur, pd, pdl, base, pa, pb;
  vd_t av, bv;
  logic signed [1:0] dl, dr, du, dd;
  logic signed [ACC_W-1:0]  tx, ty;
  logic signed [ZACC_W-1:0] tz;

  logic [ACC_W-2:0]  abs_x, abs_y;
  logic [ZACC_W-2:0] abs_z;
  logic [PX_W-1:0]   prod_x, prod_y;
  logic [PZ_W-1:0]   prod_z;
  logic [MAG_W-1:0]  mag_or;

  logic [SQ_W-1:0]   cur_sq;
  logic [M2_W:0]     trial;
  logic              ge;
  logic [15:0]       t_cand, res_new;
  logic [SQ_W-1:0]   t_sq;
  logic [16:0]       k_full;
  logic [Q_W-1:0]    k_val;
  logic              out_free;

  always_comb begin
    dl = job_r.left_edge  ? 2'sd0 : -2'sd1;
    dr = job_r.end_of_row ? 2'sd0 : 2'sd1;
    du = job_r.top_row    ? 2'sd0 : -2'sd1;
    dd = job_r.drain      ? 2'sd0 : 2'sd1;
    pc  = '{x: 2'sd0, y: 2'sd0, h: job_r.mid1};
    pl  = '{x: dl,    y: 2'sd0, h: job_r.mid0};
    pr  = '{x: dr,    y: 2'sd0, h: job_r.mid2};
    pu  = '{x: 2'sd0, y: du,    h: job_r.up1};
    pur = '{x: dr,    y: du,    h: job_r.up2};
    pd  = '{x: 2'sd0, y: dd,    h: job_r.dn1};
    pdl = '{x: dl,    y: dd,    h: job_r.dn0};
    case (tri_r)
      3'd0:    begin base = pl;  pa = pc;  pb = pdl; end
      3'd1:    begin base = pd;  pa = pdl; pb = pc;  end
      3'd2:    begin base = pc;  pa = pr;  pb = pd;  end
      3'd3:    begin base = pc;  pa = pl;  pb = pu;  end
      3'd4:    begin base = pu;  pa = pur; pb = pc;  end
      default: begin base = pr;  pa = pc;  pb = pur; end
    endcase
    av = vsub(pa, base);
    bv = vsub(pb, base);
    tx = ACC_W'(av.y) * ACC_W'(bv.z) - ACC_W'(av.z) * ACC_W'(bv.y);
    ty = ACC_W'(av.z) * ACC_W'(bv.x) - ACC_W'(av.x) * ACC_W'(bv.z);
    tz = ZACC_W'(av.x) * ZACC_W'(bv.y) - ZACC_W'(av.y) * ZACC_W'(bv.x);
  end

  always_comb begin
    abs_x  = (ACC_W-1)'(sx_r < 0 ? -sx_r : sx_r);
    abs_y  = (ACC_W-1)'(sy_r < 0 ? -sy_r : sy_r);
    abs_z  = (ZACC_W-1)'(sz_r < 0 ? -sz_r : sz_r);
    prod_x = PX_W'(abs_x) * PX_W'(ph_r);
    prod_y = PX_W'(abs_y) * PX_W'(ph_r);
    prod_z = PZ_W'(abs_z) * PZ_W'(pp_r);
    mag_or = mx_r | my_r | mz_r;
  end

  always_comb begin
    case (comp_r)
      2'd0:    cur_sq = sqx_r;
      2'd1:    cur_sq = sqy_r;
      default: cur_sq = sqz_r;
    endcase
    // Only the lowest numerator bit of m*m*2^30 below the starting remainder is non-zero.
    trial   = {rem_r, (cnt_r == '0) ? cur_sq[0] : 1'b0};
    ge      = (trial >= (M2_W+1)'(m2_r));
    t_cand  = res_r | (16'd1 << bit_r);
    t_sq    = SQ_W'(t_cand) * SQ_W'(t_cand);
    res_new = (t_sq <= SQ_W'(quo_r)) ? t_cand : res_r;
    // Largest u with u*u no larger than the quotient gives k = (u+1)/2, rounded down.
    k_full  = 17'(res_new) + 17'd1;
    k_val   = k_full[Q_W:1];
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_TRI;
      B_TRI:   if (tri_r == 3'd5) state_nxt = B_MUL1;
      B_MUL1:  state_nxt = B_MUL2;
      B_MUL2:  state_nxt = B_SHIFT;
      B_SHIFT: begin
        if (mag_or == '0) begin
          state_nxt = B_DONE;
        end else if (mag_or[MAG_W-1:16] == '0) begin
          state_nxt = B_SQ;
        end
      end
      B_SQ:    state_nxt = B_SUM;
      B_SUM:   state_nxt = B_DIV;
      B_DIV:   if (cnt_r == 5'(QD_W-1)) state_nxt = B_SQRT;
      B_SQRT:  begin
        if (bit_r == '0) begin
          state_nxt = (comp_r == 2'd2) ? B_DONE : B_DIV;
        end
      end
      B_DONE:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == B_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r <= q_job;
        tri_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sz_r  <= '0;
      end
      B_TRI: begin
        sx_r  <= sx_r + tx;
        sy_r  <= sy_r + ty;
        sz_r  <= sz_r + tz;
        tri_r <= tri_r + 1'b1;
      end
      B_MUL1: begin
        ph_r <= PH_W'(grid_pitch) * PH_W'(height_scale);
        pp_r <= PP_W'(grid_pitch) * PP_W'(grid_pitch);
      end
      B_MUL2: begin
        mx_r   <= {prod_x, 12'd0};
        my_r   <= {prod_y, 12'd0};
        mz_r   <= MAG_W'({prod_z, 24'd0});
        negx_r <= (sx_r < 0);
        negy_r <= (sy_r < 0);
        negz_r <= (sz_r < 0);
      end
      B_SHIFT: begin
        if (mag_or == '0) begin
          // Degenerate sum: the normal points straight up.
          qx_r   <= '0;
          qy_r   <= '0;
          qz_r   <= ONE_Q;
          negz_r <= 1'b0;
        end else if (mag_or[MAG_W-1:16] != '0) begin
          mx_r <= mx_r >> 1;
          my_r <= my_r >> 1;
          mz_r <= mz_r >> 1;
        end
      end
      B_SQ: begin
        sqx_r <= SQ_W'(mx_r[15:0]) * SQ_W'(mx_r[15:0]);
        sqy_r <= SQ_W'(my_r[15:0]) * SQ_W'(my_r[15:0]);
        sqz_r <= SQ_W'(mz_r[15:0]) * SQ_W'(mz_r[15:0]);
      end
      B_SUM: begin
        m2_r   <= M2_W'(sqx_r) + M2_W'(sqy_r) + M2_W'(sqz_r);
        comp_r <= 2'd0;
        cnt_r  <= '0;
        rem_r  <= M2_W'(sqx_r >> 1);
        quo_r  <= '0;
      end
      B_DIV: begin
        rem_r <= ge ? M2_W'(trial - (M2_W+1)'(m2_r)) : M2_W'(trial);
        quo_r <= {quo_r[QD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        bit_r <= 4'd15;
        res_r <= '0;
      end
      B_SQRT: begin
        res_r <= res_new;
        bit_r <= bit_r - 1'b1;
        if (bit_r == '0) begin
          case (comp_r)
            2'd0:    qx_r <= k_val;
            2'd1:    qy_r <= k_val;
            default: qz_r <= k_val;
          endcase
          comp_r <= comp_r + 1'b1;
          cnt_r  <= '0;
          quo_r  <= '0;
          rem_r  <= (comp_r == 2'd0) ? M2_W'(sqy_r >> 1) : M2_W'(sqz_r >> 1);
        end
      end
      B_DONE: begin
        if (out_free) begin
          nx_r      <= negx_r ? -$signed(hnm_pkg::NRM_W'(qx_r)) : $signed(hnm_pkg::NRM_W'(qx_r));
          ny_r      <= negy_r ? -$signed(hnm_pkg::NRM_W'(qy_r)) : $signed(hnm_pkg::NRM_W'(qy_r));
          nz_r      <= negz_r ? -$signed(hnm_pkg::NRM_W'(qz_r)) : $signed(hnm_pkg::NRM_W'(qz_r));
          eor_out_r <= job_r.end_of_row;
          eof_out_r <= job_r.end_of_row && job_r.drain;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.normal_x     = nx_r;
  assign out_ch.normal_y     = ny_r;
  assign out_ch.normal_z     = nz_r;
  assign out_ch.end_of_row   = eor_out_r;
  assign out_ch.end_of_frame = eof_out_r;

  a_mag_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQ) |-> (mag_or[MAG_W-1:16] == '0))
    else $error("magnitude still wider than 16 bits when squared");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQRT && bit_r == '0) |-> (k_val <= ONE_Q))
    else $error("normal component above one");

endmodule

// ===== verif/heightmap_normal_generator_unit_test.sv =====
// ----------------------------------------------------------------------------
// heightmap_normal_generator_unit_test
// Self-checking regression for the heightmap normal generator. A queue-fed
// driver offers height and drain items, and a predictor works out each unit
// normal when its item is accepted. A monitor compares every normal that
// leaves the block against the oldest prediction. The run goes through several
// register settings and idling patterns, and includes one long output hold-off.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 600;

  typedef struct {
    logic [hnm_pkg::HGT_W-1:0] height;
    logic                      drain;
  } sample_t;

  typedef struct {
    logic signed [hnm_pkg::NRM_W-1:0] nx;
    logic signed [hnm_pkg::NRM_W-1:0] ny;
    logic signed [hnm_pkg::NRM_W-1:0] nz;
    logic                             eor;
    logic                             eof;
  } normal_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [hnm_pkg::ADDR_W-1:0] paddr;
  logic [hnm_pkg::DATA_W-1:0] pwdata;
  logic [hnm_pkg::DATA_W-1:0] prdata;
  logic pready;

  hnm_in_if  in_ch ();
  hnm_out_if out_ch ();

  heightmap_normal_generator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's registers and line state.
  logic [hnm_pkg::PIX_W-1:0] pix_size;
  logic [hnm_pkg::HS_W-1:0]  hgt_scale;
  logic [hnm_pkg::LEN_W-1:0] row_len;
  logic [hnm_pkg::HGT_W-1:0] older_line [hnm_pkg::LINE_MAX];
  logic [hnm_pkg::HGT_W-1:0] newer_line [hnm_pkg::LINE_MAX];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [hnm_pkg::HGT_W-1:0] prev_height;
  logic [hnm_pkg::HGT_W-1:0] left_height;

  sample_t pending_samples [$];
  normal_t expected_normals [$];

  int errors;
  int normals_seen;
  int samples_taken;
  int frames_closed;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;
  logic in_fire;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic vec_t vertex(longint dx, longint dy, logic [hnm_pkg::HGT_W-1:0] h);
    vec_t v;
    longint step;
    step = longint'(pix_size) * 4096;
    v.x = dx * step;
    v.y = dy * step;
    v.z = longint'(h) * longint'(hgt_scale);
    return v;
  endfunction

  function automatic vec_t minus(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t cross_sum(vec_t acc, vec_t a, vec_t b);
    acc.x += a.y * b.z - a.z * b.y;
    acc.y += a.z * b.x - a.x * b.z;
    acc.z += a.x * b.y - a.y * b.x;
    return acc;
  endfunction

  // Largest k with (k - 1/2)^2 * m2 <= m^2 * 2^28, i.e. round(16384*m/|v|).
  function automatic logic [15:0] unit_length(longint unsigned m, longint unsigned m2);
    longint unsigned t, o;
    int unsigned lo, hi, k;
    t = (m * m) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      k = (lo + hi + 1) / 2;
      o = 2 * longint'(k) - 1;
      if (o * o * m2 <= t) lo = k;
      else hi = k - 1;
    end
    return lo[15:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [hnm_pkg::NRM_W-1:0] apply_sign(logic [15:0] q, bit neg);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Advances the shadow state by one accepted item and queues its normal.
  task automatic predict_normal(input logic [hnm_pkg::HGT_W-1:0] h, input logic dr);
    int unsigned len, last, c, cr;
    bit eor;
    logic [hnm_pkg::HGT_W-1:0] up1, up2, mid0, mid1, mid2, dn0, dn1;
    longint dl, dr_off, du, dd;
    vec_t cc, ll, rr, uu, ur, dn, dlv, s;
    longint unsigned ax, ay, az, m2;
    normal_t n;
    len = (row_len < 2) ? 2 : row_len;
    if (len > hnm_pkg::LINE_MAX) len = hnm_pkg::LINE_MAX;
    last = len - 1;
    c = (col_pos < last) ? col_pos : last;
    cr = (c < last) ? c + 1 : last;
    eor = (c == last);
    if (row_pos == 0) begin
      if (dr) return;
      older_line[c] = h;
      newer_line[c] = h;
      prev_height = h;
      col_pos = eor ? 0 : c + 1;
      if (eor) row_pos = 1;
      return;
    end
    up1 = older_line[c];
    up2 = older_line[cr];
    mid1 = newer_line[c];
    mid2 = newer_line[cr];
    mid0 = (c == 0) ? mid1 : left_height;
    dn1 = dr ? mid1 : h;
    dn0 = (c == 0) ? dn1 : prev_height;
    dl = (c == 0) ? 0 : -1;
    dr_off = eor ? 0 : 1;
    du = (row_pos == 1) ? 0 : -1;
    dd = dr ? 0 : 1;
    cc = vertex(0, 0, mid1);
    ll = vertex(dl, 0, mid0);
    rr = vertex(dr_off, 0, mid2);
    uu = vertex(0, du, up1);
    ur = vertex(dr_off, du, up2);
    dn = vertex(0, dd, dn1);
    dlv = vertex(dl, dd, dn0);
    s = '{0, 0, 0};
    s = cross_sum(s, minus(cc, ll), minus(dlv, ll));
    s = cross_sum(s, minus(dlv, dn), minus(cc, dn));
    s = cross_sum(s, minus(rr, cc), minus(dn, cc));
    s = cross_sum(s, minus(ll, cc), minus(uu, cc));
    s = cross_sum(s, minus(ur, uu), minus(cc, uu));
    s = cross_sum(s, minus(cc, rr), minus(ur, rr));
    ax = magnitude(s.x);
    ay = magnitude(s.y);
    az = magnitude(s.z);
    if ((ax | ay | az) == 0) begin
      // A flat or degenerate neighbourhood points straight up.
      n.nx = 0;
      n.ny = 0;
      n.nz = 16384;
    end else begin
      while ((ax | ay | az) >= 65536) begin
        ax >>= 1;
        ay >>= 1;
        az >>= 1;
      end
      m2 = ax * ax + ay * ay + az * az;
      n.nx = apply_sign(unit_length(ax, m2), s.x < 0);
      n.ny = apply_sign(unit_length(ay, m2), s.y < 0);
      n.nz = apply_sign(unit_length(az, m2), s.z < 0);
    end
    n.eor = eor;
    n.eof = eor && dr;
    expected_normals.push_back(n);
    older_line[c] = mid1;
    newer_line[c] = dn1;
    left_height = mid1;
    prev_height = dn1;
    col_pos = eor ? 0 : c + 1;
    if (eor) begin
      if (dr) begin
        row_pos = 0;
        frames_closed++;
      end else if (row_pos < 65535) begin
        row_pos++;
      end
    end
  endtask

  // Input acceptance and output checking, both on the rising edge.
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fire = 1'b1;
        samples_taken++;
        predict_normal(in_ch.height, in_ch.drain);
      end
      if (out_ch.valid && out_ch.ready) begin
        normals_seen++;
        if (expected_normals.size() == 0) begin
          $display("[%0t] normal received with none outstanding", $realtime);
          errors++;
        end else begin
          normal_t w;
          w = expected_normals.pop_front();
          if (out_ch.normal_x !== w.nx) report_mismatch("normal_x", out_ch.normal_x, w.nx);
          if (out_ch.normal_y !== w.ny) report_mismatch("normal_y", out_ch.normal_y, w.ny);
          if (out_ch.normal_z !== w.nz) report_mismatch("normal_z", out_ch.normal_z, w.nz);
          if (out_ch.end_of_row !== w.eor)
            report_mismatch("end_of_row", out_ch.end_of_row, w.eor);
          if (out_ch.end_of_frame !== w.eof)
            report_mismatch("end_of_frame", out_ch.end_of_frame, w.eof);
        end
      end
    end
  end

  // Item driver: a new item or a gap once the current one has gone.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t nxt;
        nxt = pending_samples.pop_front();
        in_ch.height <= nxt.height;
        in_ch.drain  <= nxt.drain;
        in_ch.valid  <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure, with an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("heightmap_normal_generator_unit regression: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hnm_pkg::ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      hnm_pkg::REG_GRID_PITCH:   pix_size  = value[hnm_pkg::PIX_W-1:0];
      hnm_pkg::REG_HEIGHT_SCALE: hgt_scale = value[hnm_pkg::HS_W-1:0];
      default:                   row_len   = value[hnm_pkg::LEN_W-1:0];
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      hnm_pkg::REG_GRID_PITCH:   if (prdata[hnm_pkg::PIX_W-1:0] !== pix_size)
                                   report_mismatch("grid pitch readback", prdata, pix_size);
      hnm_pkg::REG_HEIGHT_SCALE: if (prdata[hnm_pkg::HS_W-1:0] !== hgt_scale)
                                   report_mismatch("height_scale readback", prdata, hgt_scale);
      default:                   if (prdata[hnm_pkg::LEN_W-1:0] !== row_len)
                                   report_mismatch("row_length readback", prdata, row_len);
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_sample(input int h, input bit dr);
    sample_t s;
    s.height = h[hnm_pkg::HGT_W-1:0];
    s.drain = dr;
    pending_samples.push_back(s);
  endtask

  task automatic wait_sent();
    wait (pending_samples.size() == 0 && !in_ch.valid);
  endtask

  // Idle point: everything sent and returned, plus the back end's latency.
  task automatic wait_idle();
    wait_sent();
    wait (expected_normals.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain items until the shadow says the frame is closed, so no later row
  // length change can read an unwritten line entry.
  task automatic close_frame();
    wait_sent();
    while (row_pos != 0) begin
      push_sample($urandom_range(255), 1'b1);
      wait_sent();
    end
  endtask

  function automatic int unsigned effective_len();
    int unsigned l;
    l = (row_len < 2) ? 2 : row_len;
    return (l > hnm_pkg::LINE_MAX) ? hnm_pkg::LINE_MAX : l;
  endfunction

  function automatic int pick_height(int mode);
    case (mode)
      0:       return $urandom_range(255);
      1:       return $urandom_range(1) ? 255 : 0;
      default: return $urandom_range(16) + 120;
    endcase
  endfunction

  // Random frames: well-formed rows with a little drain noise sprinkled in.
  task automatic random_frames(input int budget);
    int sent;
    int rows;
    int mode;
    sent = 0;
    while (sent < budget) begin
      rows = $urandom_range(4, 1);
      mode = $urandom_range(2);
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < effective_len(); c++) begin
          push_sample(pick_height(mode), $urandom_range(99) < 3);
          sent++;
        end
      end
      for (int c = 0; c < effective_len(); c++) begin
        push_sample($urandom_range(255), 1'b1);
        sent++;
      end
    end
    close_frame();
  endtask

  task automatic configure(input int pix, input int hs, input int len);
    wait_idle();
    reg_write(hnm_pkg::REG_GRID_PITCH, pix);
    reg_write(hnm_pkg::REG_HEIGHT_SCALE, hs);
    reg_write(hnm_pkg::REG_ROW_LENGTH, len);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.height = '0;
    in_ch.drain = 1'b0;
    out_ch.ready = 1'b0;
    in_fire = 1'b0;
    errors = 0;
    normals_seen = 0;
    samples_taken = 0;
    frames_closed = 0;
    hold_request = 0;
    hold_left = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pix_size = hnm_pkg::GRID_PITCH_RST;
    hgt_scale = hnm_pkg::HEIGHT_SCALE_RST;
    row_len = hnm_pkg::ROW_LENGTH_RST;
    for (int i = 0; i < hnm_pkg::LINE_MAX; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    prev_height = '0;
    left_height = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: drains before any row, flat, extreme and ridged rows, a drain
    // inside a row, and the last column.
    configure(5, 4096, 4);
    push_sample(255, 1'b1);
    push_sample(0, 1'b1);
    for (int c = 0; c < 4; c++) push_sample(0, 1'b0);
    for (int c = 0; c < 4; c++) push_sample(255, 1'b0);
    push_sample(0, 1'b0);
    push_sample(77, 1'b1);
    push_sample(255, 1'b0);
    push_sample(0, 1'b0);
    for (int c = 0; c < 4; c++) push_sample(c[0] ? 255 : 0, 1'b0);
    for (int c = 0; c < 4; c++) push_sample(0, 1'b1);
    // A one-row frame, whose flush sees no slope at all.
    for (int c = 0; c < 4; c++) push_sample(200, 1'b0);
    close_frame();

    // The row length shrinks while a row is half done.
    configure(3, 803, 6);
    for (int c = 0; c < 9; c++) push_sample($urandom_range(255), 1'b0);
    wait_idle();
    reg_write(hnm_pkg::REG_ROW_LENGTH, 4);
    random_frames(60);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 19) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 85 : 19) : 0;
      case (ph)
        0: configure(64, 65535, 5);
        1: configure(0, 12000, 3);
        2: configure(127, 0, 0);
        default: configure(1, 803, 7);
      endcase
      if (ph == 0) begin
        // Stop draining the output while the sender keeps pushing.
        hold_request = 2000;
      end
      random_frames(140);
    end

    // One full row at a row length beyond the line stores, then the start of
    // its flush.
    send_idle_pct = 0;
    recv_stall_pct = 10;
    configure(9, 2222, 2047);
    for (int c = 0; c < hnm_pkg::LINE_MAX; c++) push_sample($urandom_range(255), 1'b0);
    for (int c = 0; c < 40; c++) push_sample(0, 1'b1);

    wait_idle();
    $display("Covered %0d items and %0d normals over %0d closed frames,", samples_taken,
             normals_seen, frames_closed);
    $display("across several register settings, four idling patterns and a long output stall.");
    if (errors == 0) begin
      $display("heightmap_normal_generator_unit regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("heightmap_normal_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== heightmap_normal_generator_unit.f =====
rtl/core/hnm_pkg.sv
rtl/core/hnm_if.sv
rtl/core/hnm_queue.sv
rtl/core/hnm_front.sv
rtl/core/hnm_back.sv
rtl/core/heightmap_normal_generator_unit.sv
verif/heightmap_normal_generator_unit_test.sv
